// ----- rtl/ort_pkg.sv -----
// ----------------------------------------------------------------------------
// ort_pkg
// Shared types and field offsets for the oriented rectangle overlap test.
// ----------------------------------------------------------------------------
package ort_pkg;

   // request bus layout, lowest bit first
   localparam int ReqBits   = 192;
   localparam int RspBits   = 8;
   localparam int AxLsb     = 0;
   localparam int AyLsb     = 16;
   localparam int AwLsb     = 32;
   localparam int AhLsb     = 47;
   localparam int AcLsb     = 62;
   localparam int AsLsb     = 78;
   localparam int BxLsb     = 94;
   localparam int ByLsb     = 110;
   localparam int BwLsb     = 126;
   localparam int BhLsb     = 141;
   localparam int BcLsb     = 156;
   localparam int BsLsb     = 172;
   localparam int NumAxes   = 4;
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // one classified item: axes, center differences, rotations and sizes
   typedef struct packed {
      logic [NumAxes-1:0][16:0] ax;
      logic [NumAxes-1:0][16:0] ay;
      logic [18:0]              ddx;
      logic [18:0]              ddy;
      logic [15:0]              cos_a;
      logic [15:0]              sin_a;
      logic [15:0]              cos_b;
      logic [15:0]              sin_b;
      logic [14:0]              w_a;
      logic [14:0]              h_a;
      logic [14:0]              w_b;
      logic [14:0]              h_b;
   } axis_item_type;

endpackage

// ----- rtl/ort_front.sv -----
// ----------------------------------------------------------------------------
// ort_front
// Accepts a rectangle pair, builds the four test axes and center differences.
// ----------------------------------------------------------------------------
module ort_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ort_pkg::ReqBits-1:0] req_tdata,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ort_pkg::axis_item_type    out_item
);
   import ort_pkg::*;

   logic          valid_ff, valid_in;
   axis_item_type item_ff, item_in;
   logic [15:0]   xa, ya, ca, sa, xb, yb, cb, sb;
   logic [14:0]   wa, ha, wb, hb;

   // field unpacking
   assign xa = req_tdata[AxLsb +: 16];
   assign ya = req_tdata[AyLsb +: 16];
   assign wa = req_tdata[AwLsb +: 15];
   assign ha = req_tdata[AhLsb +: 15];
   assign ca = req_tdata[AcLsb +: 16];
   assign sa = req_tdata[AsLsb +: 16];
   assign xb = req_tdata[BxLsb +: 16];
   assign yb = req_tdata[ByLsb +: 16];
   assign wb = req_tdata[BwLsb +: 15];
   assign hb = req_tdata[BhLsb +: 15];
   assign cb = req_tdata[BcLsb +: 16];
   assign sb = req_tdata[BsLsb +: 16];

   assign req_tready = !valid_ff || out_ready;

   // axes from edge directions, zero for a zero-length edge
   always_comb begin
      item_in       = item_ff;
      item_in.ax[0] = (wa != '0) ? {ca[15], ca} : '0;
      item_in.ay[0] = (wa != '0) ? {sa[15], sa} : '0;
      item_in.ax[1] = (ha != '0) ? 17'(-{sa[15], sa}) : '0;
      item_in.ay[1] = (ha != '0) ? {ca[15], ca} : '0;
      item_in.ax[2] = (wb != '0) ? {cb[15], cb} : '0;
      item_in.ay[2] = (wb != '0) ? {sb[15], sb} : '0;
      item_in.ax[3] = (hb != '0) ? 17'(-{sb[15], sb}) : '0;
      item_in.ay[3] = (hb != '0) ? {cb[15], cb} : '0;
      // doubled center of A minus doubled center of B
      item_in.ddx   = {{2{xa[15]}}, xa, 1'b0} + {4'b0, wa}
                    - {{2{xb[15]}}, xb, 1'b0} - {4'b0, wb};
      item_in.ddy   = {{2{ya[15]}}, ya, 1'b0} + {4'b0, ha}
                    - {{2{yb[15]}}, yb, 1'b0} - {4'b0, hb};
      item_in.cos_a = ca;
      item_in.sin_a = sa;
      item_in.cos_b = cb;
      item_in.sin_b = sb;
      item_in.w_a   = wa;
      item_in.h_a   = ha;
      item_in.w_b   = wb;
      item_in.h_b   = hb;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= valid_in;
      end
   end

   assign valid_in = req_tvalid;

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- rtl/ort_queue.sv -----
// ----------------------------------------------------------------------------
// ort_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module ort_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ort_pkg::axis_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ort_pkg::axis_item_type out_item
);
   import ort_pkg::*;

   axis_item_type                 mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrBits:0]         count_ff, count_in;
   logic                          push, pop;

   assign in_ready  = (count_ff != (QueuePtrBits+1)'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/ort_back.sv -----
// ----------------------------------------------------------------------------
// ort_back
// Projects both rectangles on each axis and checks for a separating gap.
// ----------------------------------------------------------------------------
module ort_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ort_pkg::axis_item_type in_item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ort_pkg::RspBits-1:0] rsp_tdata
);
   import ort_pkg::*;

   logic        adv;
   logic [2:0]  valid_ff;
   logic        out_valid_ff;
   logic        out_hit_ff, out_hit_in;

   // stage one: products
   logic signed [35:0] pdx_ff [NumAxes], pdy_ff [NumAxes];
   logic signed [32:0] uac_ff [NumAxes], uas_ff [NumAxes], vac_ff [NumAxes], vas_ff [NumAxes];
   logic signed [32:0] ubc_ff [NumAxes], ubs_ff [NumAxes], vbc_ff [NumAxes], vbs_ff [NumAxes];
   logic [14:0]        wa1_ff, ha1_ff, wb1_ff, hb1_ff;
   // stage two: magnitudes
   logic [35:0]        dab_ff [NumAxes];
   logic [33:0]        ua_ff [NumAxes], va_ff [NumAxes], ub_ff [NumAxes], vb_ff [NumAxes];
   logic [14:0]        wa2_ff, ha2_ff, wb2_ff, hb2_ff;
   // stage three: half extents
   logic [35:0]        dab3_ff [NumAxes];
   logic [48:0]        rwa_ff [NumAxes], rha_ff [NumAxes], rwb_ff [NumAxes], rhb_ff [NumAxes];

   assign adv      = !out_valid_ff || rsp_tready;
   assign in_ready = adv;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[1:0], in_valid};
         out_valid_ff <= valid_ff[2];
      end
   end

   // stage one: center and rotation products per axis
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NumAxes; k++) begin
            pdx_ff[k] <= $signed(in_item.ddx) * $signed(in_item.ax[k]);
            pdy_ff[k] <= $signed(in_item.ddy) * $signed(in_item.ay[k]);
            uac_ff[k] <= $signed(in_item.cos_a) * $signed(in_item.ax[k]);
            uas_ff[k] <= $signed(in_item.sin_a) * $signed(in_item.ay[k]);
            vac_ff[k] <= $signed(in_item.cos_a) * $signed(in_item.ay[k]);
            vas_ff[k] <= $signed(in_item.sin_a) * $signed(in_item.ax[k]);
            ubc_ff[k] <= $signed(in_item.cos_b) * $signed(in_item.ax[k]);
            ubs_ff[k] <= $signed(in_item.sin_b) * $signed(in_item.ay[k]);
            vbc_ff[k] <= $signed(in_item.cos_b) * $signed(in_item.ay[k]);
            vbs_ff[k] <= $signed(in_item.sin_b) * $signed(in_item.ax[k]);
         end
         wa1_ff <= in_item.w_a;
         ha1_ff <= in_item.h_a;
         wb1_ff <= in_item.w_b;
         hb1_ff <= in_item.h_b;
      end
   end

   // stage two: sums and absolute values
   always_ff @(posedge clock) begin
      logic signed [36:0] d;
      logic signed [33:0] ua, va, ub, vb;
      if (adv) begin
         for (int k = 0; k < NumAxes; k++) begin
            d  = 37'(pdx_ff[k]) + 37'(pdy_ff[k]);
            ua = 34'(uac_ff[k]) + 34'(uas_ff[k]);
            va = 34'(vac_ff[k]) - 34'(vas_ff[k]);
            ub = 34'(ubc_ff[k]) + 34'(ubs_ff[k]);
            vb = 34'(vbc_ff[k]) - 34'(vbs_ff[k]);
            dab_ff[k] <= 36'((d < 0) ? -d : d);
            ua_ff[k]  <= (ua < 0) ? -ua : ua;
            va_ff[k]  <= (va < 0) ? -va : va;
            ub_ff[k]  <= (ub < 0) ? -ub : ub;
            vb_ff[k]  <= (vb < 0) ? -vb : vb;
         end
         wa2_ff <= wa1_ff;
         ha2_ff <= ha1_ff;
         wb2_ff <= wb1_ff;
         hb2_ff <= hb1_ff;
      end
   end

   // stage three: projection half extents
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NumAxes; k++) begin
            dab3_ff[k] <= dab_ff[k];
            rwa_ff[k]  <= 49'(wa2_ff) * 49'(ua_ff[k]);
            rha_ff[k]  <= 49'(ha2_ff) * 49'(va_ff[k]);
            rwb_ff[k]  <= 49'(wb2_ff) * 49'(ub_ff[k]);
            rhb_ff[k]  <= 49'(hb2_ff) * 49'(vb_ff[k]);
         end
      end
   end

   // stage four: gap check, center distance scaled by the trig unit
   always_comb begin
      logic [51:0] reach;
      logic [51:0] gap;
      out_hit_in = 1'b1;
      for (int k = 0; k < NumAxes; k++) begin
         reach = 52'(rwa_ff[k]) + 52'(rha_ff[k]) + 52'(rwb_ff[k]) + 52'(rhb_ff[k]);
         gap   = {2'b0, dab3_ff[k], 14'b0};
         if (gap > reach) begin
            out_hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff <= out_hit_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspBits-1){1'b0}}, out_hit_ff};

endmodule

// ----- rtl/oriented_rect_overlap_test.sv -----
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test
// Separating axis test for two rotated rectangles, one pair per cycle while the response side does not stall.
// ----------------------------------------------------------------------------
// path: front stage register, queue entry, back product, magnitude and half extent stages, result register
// throughput: one item per cycle while the response side does not stall, set by the fully pipelined multiply stages
// a four-entry queue lets the front keep accepting while the back is stalled
// reset: synchronous, active high, empties all stages and the queue
module oriented_rect_overlap_test (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // a: x, y, width, height, cosine, sine; then the same for b; zero pad
   input  logic [ort_pkg::ReqBits-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // overlapping; zero pad
   output logic [ort_pkg::RspBits-1:0] rsp_tdata
);
   import ort_pkg::*;

   logic          f_valid, f_ready, q_valid, q_ready;
   axis_item_type f_item, q_item;

   // front: classify and set up axes
   ort_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_item   (f_item)
   );

   // queue between front and back
   ort_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // back: projections and compare
   ort_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/oriented_rect_overlap_test_tb.sv -----
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test_tb
// Streams rectangle pairs into the overlap test with random bursts and output
// stalls, predicts each answer with an exact separating axis computation and
// compares every response in order.
// ----------------------------------------------------------------------------
module oriented_rect_overlap_test_tb;
   import ort_pkg::*;

   typedef struct {
      logic signed [15:0] x, y;
      logic [14:0]        w, h;
      logic signed [15:0] c, s;
   } rect_type;

   typedef struct {
      rect_type a, b;
   } pair_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqBits-1:0]  req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspBits-1:0]  rsp_tdata;

   logic [ReqBits-1:0]  pair_queue[$];
   logic                overlap_queue[$];
   int                  error_count;
   int                  checked_count;
   int                  hit_count;
   bit                  stim_done;

   oriented_rect_overlap_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // corners of one rectangle at scale 2 * 2^14 of Q12.4
   function automatic void rect_corners(input rect_type r, output longint px[4],
                                        output longint py[4]);
      longint mx, my, dx, dy, w, h, c, s;
      w = r.w; h = r.h; c = r.c; s = r.s;
      mx = (2 * longint'(r.x) + w) * 16384;
      my = (2 * longint'(r.y) + h) * 16384;
      for (int k = 0; k < 4; k++) begin
         dx = k[0] ? w : -w;
         dy = k[1] ? h : -h;
         px[k] = mx + dx * c - dy * s;
         py[k] = my + dx * s + dy * c;
      end
   endfunction

   function automatic void span(input longint px[4], input longint py[4],
                                input longint ux, input longint uy,
                                output longint lo, output longint hi);
      longint p;
      lo = px[0] * ux + py[0] * uy;
      hi = lo;
      for (int k = 1; k < 4; k++) begin
         p = px[k] * ux + py[k] * uy;
         if (p < lo) lo = p;
         if (p > hi) hi = p;
      end
   endfunction

   // exact separating axis decision
   function automatic logic rects_overlap(input pair_type p);
      longint apx[4], apy[4], bpx[4], bpy[4];
      longint ux[4], uy[4];
      longint loa, hia, lob, hib;
      rect_corners(p.a, apx, apy);
      rect_corners(p.b, bpx, bpy);
      ux[0] = (p.a.w != 0) ? longint'(p.a.c) : 0;
      uy[0] = (p.a.w != 0) ? longint'(p.a.s) : 0;
      ux[1] = (p.a.h != 0) ? -longint'(p.a.s) : 0;
      uy[1] = (p.a.h != 0) ? longint'(p.a.c) : 0;
      ux[2] = (p.b.w != 0) ? longint'(p.b.c) : 0;
      uy[2] = (p.b.w != 0) ? longint'(p.b.s) : 0;
      ux[3] = (p.b.h != 0) ? -longint'(p.b.s) : 0;
      uy[3] = (p.b.h != 0) ? longint'(p.b.c) : 0;
      for (int k = 0; k < NumAxes; k++) begin
         span(apx, apy, ux[k], uy[k], loa, hia);
         span(bpx, bpy, ux[k], uy[k], lob, hib);
         if (hia < lob || loa > hib) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [ReqBits-1:0] pack_pair(input pair_type p);
      logic [ReqBits-1:0] d;
      d = '0;
      d[AxLsb +: 16] = p.a.x;  d[AyLsb +: 16] = p.a.y;
      d[AwLsb +: 15] = p.a.w;  d[AhLsb +: 15] = p.a.h;
      d[AcLsb +: 16] = p.a.c;  d[AsLsb +: 16] = p.a.s;
      d[BxLsb +: 16] = p.b.x;  d[ByLsb +: 16] = p.b.y;
      d[BwLsb +: 15] = p.b.w;  d[BhLsb +: 15] = p.b.h;
      d[BcLsb +: 16] = p.b.c;  d[BsLsb +: 16] = p.b.s;
      return d;
   endfunction

   function automatic logic signed [15:0] rand_trig(input int mode);
      case (mode)
         0: return 16'(int'($urandom_range(0, 32768)) - 16384);
         1: return 16'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'sd16384;
               1: return -16'sd16384;
               2: return 16'sd0;
               3: return 16'sd11585;
               default: return -16'sd11585;
            endcase
         end
      endcase
   endfunction

   function automatic rect_type rand_rect(input int sz, input logic signed [15:0] ox,
                                          input logic signed [15:0] oy);
      rect_type r;
      int       mode;
      mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      if (sz == 0) begin
         r.x = ox + 16'($urandom_range(0, 2048)) - 16'sd1024;
         r.y = oy + 16'($urandom_range(0, 2048)) - 16'sd1024;
         r.w = 15'($urandom_range(0, 1024));
         r.h = 15'($urandom_range(0, 1024));
      end else begin
         r.x = 16'($urandom);
         r.y = 16'($urandom);
         r.w = 15'($urandom);
         r.h = 15'($urandom);
      end
      if ($urandom_range(0, 19) == 0) r.w = '0;
      if ($urandom_range(0, 19) == 0) r.h = '0;
      r.c = rand_trig(mode);
      r.s = rand_trig(mode);
      if ($urandom_range(0, 29) == 0) begin
         r.c = '0;
         r.s = '0;
      end
      return r;
   endfunction

   function automatic rect_type mk(input int x, y, w, h, c, s);
      rect_type r;
      r.x = 16'(x); r.y = 16'(y); r.w = 15'(w); r.h = 15'(h);
      r.c = 16'(c); r.s = 16'(s);
      return r;
   endfunction

   task automatic add_pair(input pair_type p);
      pair_queue.push_back(pack_pair(p));
   endtask

   // stimulus: directed corners first, then mostly nearby random pairs
   initial begin
      pair_type p;
      logic signed [15:0] ox, oy;
      // identical unit squares
      p.a = mk(0, 0, 16, 16, 16384, 0);        p.b = p.a; add_pair(p);
      // touching edges, then just apart
      p.b = mk(16, 0, 16, 16, 16384, 0);       add_pair(p);
      p.b = mk(17, 0, 16, 16, 16384, 0);       add_pair(p);
      // diagonal gap caught only by a rotated axis
      p.a = mk(0, 0, 160, 160, 11585, 11585);
      p.b = mk(200, 200, 160, 160, 11585, 11585); add_pair(p);
      p.b = mk(120, 120, 160, 160, 0, 16384);  add_pair(p);
      // zero width and zero height edges
      p.a = mk(0, 0, 0, 32, 16384, 0);         p.b = mk(-8, 8, 32, 0, 16384, 0);
      add_pair(p);
      p.a = mk(0, 0, 0, 0, 16384, 0);          p.b = mk(100, 100, 0, 0, 16384, 0);
      add_pair(p);
      // zero trig pair collapses to center
      p.a = mk(0, 0, 64, 64, 0, 0);            p.b = mk(10, 10, 64, 64, 16384, 0);
      add_pair(p);
      p.b = mk(500, 500, 64, 64, 0, 0);        add_pair(p);
      // trig beyond unit magnitude scales the rectangle
      p.a = mk(0, 0, 100, 100, -32768, -32768); p.b = mk(300, 0, 50, 50, 32767, 32767);
      add_pair(p);
      // extreme positions and sizes
      p.a = mk(-32768, -32768, 32767, 32767, 16384, 0);
      p.b = mk(32767, 32767, 32767, 32767, -16384, 0); add_pair(p);
      p.a = mk(-32768, 32767, 32767, 0, 0, -16384);
      p.b = mk(32767, -32768, 0, 32767, -32768, 16384); add_pair(p);
      p.a = mk(32767, 32767, 32767, 32767, 32767, -32768);
      p.b = mk(-32768, -32768, 32767, 32767, -32768, 32767); add_pair(p);
      p.a = mk(-1, -1, 1, 1, -1, -1);          p.b = mk(0, 0, 1, 1, 1, 1); add_pair(p);
      p.a = mk(-21846, 21845, 21845, 10922, 21845, -21846);
      p.b = mk(21845, -21846, 10922, 21845, -21846, 21845); add_pair(p);
      // random part
      repeat (1100) begin
         ox = 16'($urandom);
         oy = 16'($urandom);
         p.a = rand_rect($urandom_range(0, 7) == 0, ox, oy);
         p.b = rand_rect($urandom_range(0, 7) == 0, ox, oy);
         add_pair(p);
      end
   end

   // sender: bursts with random gaps, inputs move on the falling edge
   int  burst_left;
   int  gap_left;

   // handshake seen at the last rising edge
   logic req_tready_q;

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      burst_left = 0;
      gap_left   = 0;
      stim_done  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_q) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
               req_tdata  <= pair_queue.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
               stim_done  <= 1'b1;
            end
         end
      end
   end

   // prediction on acceptance
   initial req_tready_q = 1'b0;

   always @(posedge clock) begin
      req_tready_q <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         overlap_queue.push_back(rects_overlap(unpack_pair(req_tdata)));
      end
   end

   function automatic pair_type unpack_pair(input logic [ReqBits-1:0] d);
      pair_type p;
      p.a.x = d[AxLsb +: 16]; p.a.y = d[AyLsb +: 16];
      p.a.w = d[AwLsb +: 15]; p.a.h = d[AhLsb +: 15];
      p.a.c = d[AcLsb +: 16]; p.a.s = d[AsLsb +: 16];
      p.b.x = d[BxLsb +: 16]; p.b.y = d[ByLsb +: 16];
      p.b.w = d[BwLsb +: 15]; p.b.h = d[BhLsb +: 15];
      p.b.c = d[BcLsb +: 16]; p.b.s = d[BsLsb +: 16];
      return p;
   endfunction

   // receiver stall pattern: always ready for part of each period, random stalls in the rest
   int stall_phase;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 200;
         if (stall_phase < 60) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 9) < 6);
      end
   end

   // response checker
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (overlap_queue.size() == 0) begin
            $display("%0t: response with nothing pending, actual overlapping=%0b",
                     $time, rsp_tdata[0]);
            error_count++;
         end else begin
            want = overlap_queue.pop_front();
            checked_count++;
            if (want) hit_count++;
            if (rsp_tdata[0] !== want || rsp_tdata[RspBits-1:1] !== '0) begin
               $display("%0t: overlapping expected %0b actual %0b (tdata %h)",
                        $time, want, rsp_tdata[0], rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      error_count   = 0;
      checked_count = 0;
      hit_count     = 0;
      @(negedge reset);
      wait (stim_done && !req_tvalid && overlap_queue.size() == 0);
      repeat (50) @(posedge clock);
      $display("checked %0d rectangle pairs, %0d overlapping and %0d separated",
               checked_count, hit_count, checked_count - hit_count);
      if (error_count == 0 && overlap_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // timeout
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
